>>> hdl/assert_macros.svh
// Assertion macros shared by the display driver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/msd_pkg.sv
// Shared types, codes and the segment table of the seven-segment display driver.
`timescale 1ns / 1ps

package msd_pkg;

  // Command codes; codes six and seven are unused and do nothing.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RAW   = 3'd1;
  localparam logic [2:0] CMD_HEX   = 3'd2;
  localparam logic [2:0] CMD_PRINT = 3'd3;
  localparam logic [2:0] CMD_POINT = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  // Point register value that lights no point.
  localparam logic [3:0] NO_POINT = 4'd8;

  // Digit select for digit zero; digit k selects bit 12 + k.
  localparam logic [15:0] SEL_BASE = 16'h1000;

  // Decimal range of the four digits.
  localparam logic [13:0] PRINT_MOD = 14'd10000;

  // Fixed-point reciprocals for the constant divisions of a value below 10000.
  localparam logic [15:0] RECIP10   = 16'd52429;  // shift 19
  localparam logic [12:0] RECIP100  = 13'd5243;   // shift 19
  localparam logic [13:0] RECIP1000 = 14'd8389;   // shift 23

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Command as classified by the front stage.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  pos;
    logic [7:0]  segments;
    logic [3:0]  digit;
    logic [13:0] m;         // number reduced below 10000
    logic        wr_tens;
    logic        wr_hund;
    logic        wr_thou;
  } msd_cmd_t;

  // Queue entry: the command plus the decimal quotients of m.
  typedef struct packed {
    msd_cmd_t    base;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
  } msd_op_t;

  // Segment pattern of a hex digit, a in bit 7 down to g in bit 1.
  function automatic logic [7:0] seg_encode(input logic [3:0] value);
    logic [7:0] pat;
    case (value)
      4'h0: pat = 8'hFC;
      4'h1: pat = 8'h60;
      4'h2: pat = 8'hDA;
      4'h3: pat = 8'hF2;
      4'h4: pat = 8'h66;
      4'h5: pat = 8'hB6;
      4'h6: pat = 8'hBE;
      4'h7: pat = 8'hE0;
      4'h8: pat = 8'hFE;
      4'h9: pat = 8'hF6;
      4'hA: pat = 8'hEE;
      4'hB: pat = 8'h3E;
      4'hC: pat = 8'h9C;
      4'hD: pat = 8'h7A;
      4'hE: pat = 8'h9E;
      4'hF: pat = 8'h8E;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

>>> hdl/msd_in_if.sv
// Command channel of the display driver.
`timescale 1ns / 1ps

interface msd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [1:0]  position;
  logic [7:0]  segments;
  logic [3:0]  digit;
  logic [13:0] number;
  logic        show_zero;

  modport source (output valid, cmd, position, segments, digit, number, show_zero,
                  input ready);
  modport sink (input valid, cmd, position, segments, digit, number, show_zero,
                output ready);
endinterface

>>> hdl/msd_out_if.sv
// Result channel of the display driver.
`timescale 1ns / 1ps

interface msd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] shift_word;
  logic        latch_pulse;

  modport source (output valid, shift_word, latch_pulse, input ready);
  modport sink (input valid, shift_word, latch_pulse, output ready);
endinterface

>>> hdl/msd_queue.sv
// Short FIFO of classified commands between the front and back stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  msd_pkg::msd_op_t push_op,
  output logic             full,
  output logic             head_vld,
  output msd_pkg::msd_op_t head_op,
  input  logic             pop
);
  import msd_pkg::*;

  msd_op_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_op  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  `MSD_ASSERT_NOW(a_q_no_overflow, push, !full, "queue written while full")
  `MSD_ASSERT_NOW(a_q_no_underflow, pop, head_vld, "queue read while empty")

endmodule

>>> hdl/msd_front.sv
// Front stage: accepts command requests, reduces numbers and forms decimal quotients.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msd_front (
  input  logic             clk,
  input  logic             rst_n,
  msd_in_if.sink           in_chan,
  output logic             push,
  output msd_pkg::msd_op_t push_op,
  input  logic             q_full
);
  import msd_pkg::*;

  logic       f_vld_r, f_vld_nxt;
  msd_cmd_t   f_cmd_r, f_cmd_nxt;
  logic       in_fire;
  logic       f_known;
  logic       f_take;
  logic [29:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;

  // Unused command codes are consumed here and never reach the queue.
  assign f_known = (f_cmd_r.cmd == CMD_TICK) || (f_cmd_r.cmd == CMD_RAW) ||
                   (f_cmd_r.cmd == CMD_HEX) || (f_cmd_r.cmd == CMD_PRINT) ||
                   (f_cmd_r.cmd == CMD_POINT) || (f_cmd_r.cmd == CMD_CLEAR);
  assign push    = f_vld_r && f_known && !q_full;
  assign f_take  = push || (f_vld_r && !f_known);
  assign in_chan.ready = !f_vld_r || f_take;
  assign in_fire = in_chan.valid && in_chan.ready;

  // Classify the incoming request and bring the number below 10000.
  always_comb begin
    f_cmd_nxt          = f_cmd_r;
    f_vld_nxt          = f_vld_r && !f_take;
    if (in_fire) begin
      f_vld_nxt          = 1'b1;
      f_cmd_nxt.cmd      = in_chan.cmd;
      f_cmd_nxt.pos      = in_chan.position;
      f_cmd_nxt.segments = in_chan.segments;
      f_cmd_nxt.digit    = in_chan.digit;
      f_cmd_nxt.m        = (in_chan.number >= PRINT_MOD) ? in_chan.number - PRINT_MOD
                                                         : in_chan.number;
      f_cmd_nxt.wr_tens  = in_chan.show_zero || (in_chan.number > 14'd9);
      f_cmd_nxt.wr_hund  = in_chan.show_zero || (in_chan.number > 14'd99);
      f_cmd_nxt.wr_thou  = in_chan.show_zero || (in_chan.number > 14'd999);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_cmd_r <= f_cmd_nxt;
  end

  // Constant divisions by reciprocal multiply; the queue entry registers them.
  assign p10   = 30'(f_cmd_r.m) * 30'(RECIP10);
  assign p100  = 27'(f_cmd_r.m) * 27'(RECIP100);
  assign p1000 = 28'(f_cmd_r.m) * 28'(RECIP1000);

  always_comb begin
    push_op.base  = f_cmd_r;
    push_op.q10   = p10[28:19];
    push_op.q100  = p100[25:19];
    push_op.q1000 = p1000[26:23];
  end

  `MSD_ASSERT_NOW(a_front_mod_range, f_vld_r, f_cmd_r.m < PRINT_MOD,
                  "reduced number out of decimal range")
  `MSD_ASSERT_NEXT(a_front_hold, f_vld_r && !f_take, f_vld_r && $stable(f_cmd_r),
                   "stalled front command lost or changed")

endmodule

>>> hdl/msd_back.sv
// Back stage: applies commands to the digit store and issues scan results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_vld,
  input  msd_pkg::msd_op_t head_op,
  output logic             pop,
  msd_out_if.source        out_chan
);
  import msd_pkg::*;

  logic [7:0]  store_r [4];
  logic [7:0]  store_nxt [4];
  logic [3:0]  point_r, point_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [15:0] out_word_r, out_word_nxt;
  logic        out_latch_r, out_latch_nxt;
  logic        is_tick;
  logic [1:0]  k;
  logic [7:0]  lit;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;
  logic [3:0]  d0, d1, d2;

  assign is_tick = (head_op.base.cmd == CMD_TICK);
  // A tick waits only while a result still sits unread in the output register.
  assign pop = head_vld && (!is_tick || !out_vld_r || out_chan.ready);

  // Decimal digits from the quotients: remainder of each by ten.
  assign r0 = head_op.base.m - ((14'(head_op.q10) << 3) + (14'(head_op.q10) << 1));
  assign r1 = head_op.q10 - ((10'(head_op.q100) << 3) + (10'(head_op.q100) << 1));
  assign r2 = head_op.q100 - ((7'(head_op.q1000) << 3) + (7'(head_op.q1000) << 1));
  assign d0 = r0[3:0];
  assign d1 = r1[3:0];
  assign d2 = r2[3:0];

  // Scan word for the current digit.
  assign k   = phase_r[2:1];
  assign lit = store_r[k] | {7'd0, (point_r == {2'b00, k})};

  always_comb begin
    store_nxt     = store_r;
    point_nxt     = point_r;
    phase_nxt     = phase_r;
    out_vld_nxt   = out_vld_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    out_latch_nxt = out_latch_r;
    if (pop) begin
      case (head_op.base.cmd)
        CMD_TICK: begin
          out_vld_nxt = 1'b1;
          phase_nxt   = phase_r + 3'd1;
          if (phase_r[0]) begin
            out_word_nxt  = '0;
            out_latch_nxt = 1'b1;
          end else begin
            out_word_nxt  = (SEL_BASE << k) | {8'h00, ~lit};
            out_latch_nxt = 1'b0;
          end
        end
        CMD_RAW: begin
          store_nxt[head_op.base.pos] = head_op.base.segments;
        end
        CMD_HEX: begin
          store_nxt[head_op.base.pos] = seg_encode(head_op.base.digit);
        end
        CMD_PRINT: begin
          store_nxt[3] = seg_encode(d0);
          if (head_op.base.wr_tens) begin
            store_nxt[2] = seg_encode(d1);
          end
          if (head_op.base.wr_hund) begin
            store_nxt[1] = seg_encode(d2);
          end
          if (head_op.base.wr_thou) begin
            store_nxt[0] = seg_encode(head_op.q1000);
          end
        end
        CMD_POINT: begin
          point_nxt = (head_op.base.pos == 2'd0) ? NO_POINT
                                                 : {2'b00, head_op.base.pos ^ 2'b11};
        end
        CMD_CLEAR: begin
          for (int i = 0; i < 4; i++) begin
            store_nxt[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        store_r[i] <= '0;
      end
      point_r   <= NO_POINT;
      phase_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      store_r   <= store_nxt;
      point_r   <= point_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    out_latch_r <= out_latch_nxt;
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.shift_word  = out_word_r;
  assign out_chan.latch_pulse = out_latch_r;

  `MSD_ASSERT_NEXT(a_back_tick_out, pop && is_tick,
                   out_vld_r && (out_latch_r == $past(phase_r[0])),
                   "tick did not produce the result for its phase")
  `MSD_ASSERT_NEXT(a_back_phase_step, pop && is_tick, phase_r == $past(phase_r) + 3'd1,
                   "scan phase did not advance on a tick")

endmodule

>>> hdl/multiplexed_seven_segment_driver.sv
// Top level of the four-digit multiplexed seven-segment display driver.
//
// Usage: commands arrive as requests on in_chan (valid/ready). Tick requests each
// produce one request on out_chan: on even scan phases a 16-bit word for the
// shift-register chain (digit select in bits 12..15, active-low segments in bits
// 0..7), on odd phases a latch pulse with a zero word. All other commands only
// update the digit store or the point and produce nothing.
// A tick passes the front register, a queue entry and the output register before
// its result shows on out_chan. Throughput: one command per cycle while out_chan
// does not stall; the front stage, a four-entry queue and the back stage each
// advance every cycle.
// Reset (rst_n low, synchronous) blanks all digits, turns the point off, sets the
// scan phase to zero and empties the pipeline.
// When out_chan stalls, the pending result holds; writes keep flowing past it
// until the next tick reaches the back stage, after which the queue fills and
// in_chan.ready drops.
`timescale 1ns / 1ps

module multiplexed_seven_segment_driver (
  input  logic       clk,
  input  logic       rst_n,
  msd_in_if.sink     in_chan,
  msd_out_if.source  out_chan
);
  import msd_pkg::*;

  logic    push;
  msd_op_t push_op;
  logic    q_full;
  logic    head_vld;
  msd_op_t head_op;
  logic    pop;

  msd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .push    (push),
    .push_op (push_op),
    .q_full  (q_full)
  );

  msd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .full     (q_full),
    .head_vld (head_vld),
    .head_op  (head_op),
    .pop      (pop)
  );

  msd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head_op  (head_op),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the multiplexed seven-segment display driver.
`timescale 1ns / 1ps

module tb;
  import msd_pkg::*;

  // Codes six and seven are spare and must leave the driver untouched.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 333;

  // One command request as it crosses the input channel.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  position;
    logic [7:0]  segments;
    logic [3:0]  digit;
    logic [13:0] number;
    logic        show_zero;
  } disp_req_t;

  // One item for the shift-register chain.
  typedef struct packed {
    logic [15:0] shift_word;
    logic        latch_pulse;
  } chain_item_t;

  // Tracks the display state and the chain items that ticks should produce.
  class display_scoreboard;
    logic [2:0]  scan_phase;
    logic [7:0]  digit_segs [4];
    logic [3:0]  point_at;
    chain_item_t chain_q [$];
    int unsigned errors;

    function new();
      scan_phase = '0;
      foreach (digit_segs[i]) digit_segs[i] = 8'h00;
      point_at = NO_POINT;
      errors = 0;
    endfunction

    function int pending();
      return chain_q.size();
    endfunction

    // Standard segment pattern, a in bit 7 down to g in bit 1.
    function logic [7:0] hex_pattern(input logic [3:0] v);
      logic [7:0] pats [16];
      pats = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
               8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E};
      return pats[v];
    endfunction

    // Apply one accepted request to the display state.
    function void note_request(input disp_req_t r);
      chain_item_t item;
      logic [1:0]  k;
      logic [7:0]  lit;
      int          m;
      case (r.cmd)
        CMD_TICK: begin
          k = scan_phase[2:1];
          if (scan_phase[0]) begin
            item.shift_word = 16'h0000;
            item.latch_pulse = 1'b1;
          end else begin
            lit = digit_segs[k] | ((point_at == {2'b00, k}) ? 8'h01 : 8'h00);
            item.shift_word = (SEL_BASE << k) | {8'h00, ~lit};
            item.latch_pulse = 1'b0;
          end
          chain_q.push_back(item);
          scan_phase = scan_phase + 3'd1;
        end
        CMD_RAW: digit_segs[r.position] = r.segments;
        CMD_HEX: digit_segs[r.position] = hex_pattern(r.digit);
        CMD_PRINT: begin
          // Units always; upper digits only when shown or significant.
          m = int'(r.number) % int'(PRINT_MOD);
          digit_segs[3] = hex_pattern(4'(m % 10));
          if (r.show_zero || r.number > 9) digit_segs[2] = hex_pattern(4'((m / 10) % 10));
          if (r.show_zero || r.number > 99) digit_segs[1] = hex_pattern(4'((m / 100) % 10));
          if (r.show_zero || r.number > 999) digit_segs[0] = hex_pattern(4'((m / 1000) % 10));
        end
        CMD_POINT: point_at = (r.position == 2'd0) ? NO_POINT : {2'b00, r.position ^ 2'd3};
        CMD_CLEAR: foreach (digit_segs[i]) digit_segs[i] = 8'h00;
        default: ;
      endcase
    endfunction

    // Compare one accepted chain item with the oldest expected one.
    function void check_result(input chain_item_t got);
      chain_item_t want;
      if (chain_q.size() == 0) begin
        $display("%0t: unexpected chain item: expected none, actual word %h latch %b",
                 $time, got.shift_word, got.latch_pulse);
        errors++;
        return;
      end
      want = chain_q.pop_front();
      if (got.shift_word !== want.shift_word) begin
        $display("%0t: shift_word mismatch: expected %h, actual %h",
                 $time, want.shift_word, got.shift_word);
        errors++;
      end
      if (got.latch_pulse !== want.latch_pulse) begin
        $display("%0t: latch_pulse mismatch: expected %b, actual %b",
                 $time, want.latch_pulse, got.latch_pulse);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_seq;
  int   quiet_cycles;

  display_scoreboard sb = new();

  msd_in_if  in_chan ();
  msd_out_if out_chan ();

  multiplexed_seven_segment_driver DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off each time one is requested.
  initial begin
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitor both channels and watch for a stuck run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result(chain_item_t'{out_chan.shift_word, out_chan.latch_pulse});
      end
      if (in_chan.valid && in_chan.ready) begin
        sb.note_request(disp_req_t'{in_chan.cmd, in_chan.position, in_chan.segments,
                                    in_chan.digit, in_chan.number, in_chan.show_zero});
      end
      if ((out_chan.valid && out_chan.ready) || (in_chan.valid && in_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_request(input logic [2:0] cmd, input logic [1:0] pos,
                              input logic [7:0] seg, input logic [3:0] dig,
                              input logic [13:0] num, input logic zero);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.cmd       <= cmd;
    in_chan.position  <= pos;
    in_chan.segments  <= seg;
    in_chan.digit     <= dig;
    in_chan.number    <= num;
    in_chan.show_zero <= zero;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected chain item has come out.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random requests: mostly ticks and writes, a few spare codes as noise.
  task automatic run_random_phase(input int count, input int sidle, input int ridle,
                                  input bit long_hold);
    int          done;
    int          pick;
    logic [2:0]  c;
    logic [13:0] n;
    done = 0;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    if (long_hold) hold_seq <= hold_seq + 1;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 40) c = CMD_TICK;
      else if (pick < 52) c = CMD_RAW;
      else if (pick < 64) c = CMD_HEX;
      else if (pick < 80) c = CMD_PRINT;
      else if (pick < 90) c = CMD_POINT;
      else if (pick < 95) c = CMD_CLEAR;
      else c = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
      // Spread numbers over every count of significant digits and above the range.
      case ($urandom_range(4))
        0: n = 14'($urandom_range(9, 0));
        1: n = 14'($urandom_range(99, 10));
        2: n = 14'($urandom_range(999, 100));
        3: n = 14'($urandom_range(9999, 1000));
        default: n = 14'($urandom_range(16383, 10000));
      endcase
      send_request(c, 2'($urandom_range(3)), 8'($urandom_range(255)),
                   4'($urandom_range(15)), n, 1'($urandom_range(1)));
      if (c != CMD_SPARE6 && c != CMD_SPARE7) done++;
    end
    wait_drained();
  endtask

  // Main sequence: reset, directed requests, three random phases, final check.
  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq = 0;
    quiet_cycles = 0;
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_TICK;
    in_chan.position = 2'd0;
    in_chan.segments = 8'h00;
    in_chan.digit = 4'h0;
    in_chan.number = 14'd0;
    in_chan.show_zero = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Raw extremes, point on the leftmost digit, then hex writes and ticks over the first two digits.
    send_request(CMD_RAW, 2'd0, 8'hFF, 4'h0, 14'd0, 1'b0);
    send_request(CMD_RAW, 2'd3, 8'h00, 4'hF, 14'd16383, 1'b1);
    send_request(CMD_POINT, 2'd3, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd3, 8'hFF, 4'hF, 14'd16383, 1'b1);
    send_request(CMD_HEX, 2'd1, 8'h00, 4'hF, 14'd0, 1'b0);
    send_request(CMD_HEX, 2'd2, 8'hFF, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    // Largest in-range number without leading zeros, then a lone units digit.
    send_request(CMD_PRINT, 2'd0, 8'h00, 4'h0, 14'd9999, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_PRINT, 2'd0, 8'h00, 4'h0, 14'd5, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    // Number above the range, zero with leading zeros shown, every point place.
    send_request(CMD_PRINT, 2'd0, 8'h00, 4'h0, 14'd16383, 1'b0);
    send_request(CMD_PRINT, 2'd0, 8'h00, 4'h0, 14'd0, 1'b1);
    send_request(CMD_POINT, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_POINT, 2'd1, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_POINT, 2'd2, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    // Clear and the spare codes, then scan again.
    send_request(CMD_CLEAR, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_SPARE6, 2'd3, 8'hFF, 4'hF, 14'd16383, 1'b1);
    send_request(CMD_SPARE7, 2'd3, 8'hFF, 4'hF, 14'd16383, 1'b1);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    send_request(CMD_TICK, 2'd0, 8'h00, 4'h0, 14'd0, 1'b0);
    wait_drained();

    run_random_phase(PHASE_ITEMS, 32, 82, 1'b0);
    run_random_phase(PHASE_ITEMS, 82, 32, 1'b0);
    run_random_phase(PHASE_ITEMS, 0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/msd_pkg.sv
hdl/msd_in_if.sv
hdl/msd_out_if.sv
hdl/msd_queue.sv
hdl/msd_front.sv
hdl/msd_back.sv
hdl/multiplexed_seven_segment_driver.sv
tb/tb.sv
